/* rtl/ithd_pkg.sv */
// ----------------------------------------------------------------------------
// ithd_pkg
// Shared types and constants of the preorder-tree Huffman decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ithd_pkg;

  localparam int unsigned INNER_NODES_DEF = 256;

  localparam logic [31:0] XOR_KEY  = 32'h6393528E ^ 32'h00004B4D;
  localparam logic [9:0]  SENTINEL = 10'h3FF;
  localparam logic [9:0]  NODE_BASE = 10'd256;

  // configuration register indexes
  localparam logic CFG_ENCRYPTED  = 1'b0;
  localparam logic CFG_OUT_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LEAF,
    PH_DECODE,
    PH_IDLE
  } phase_e;

  typedef enum logic [2:0] {
    ST_WAIT,   // wait for the next word
    ST_BIT,    // take one bit of the buffer
    ST_DONE,   // a subtree finished, value in val_q
    ST_POP,    // stack top read issued, data arrives
    ST_DEC     // child entries read issued, data arrives
  } state_e;

endpackage

`default_nettype wire

/* rtl/ithd_ram.sv */
// ----------------------------------------------------------------------------
// ithd_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ithd_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/inline_tree_huffman_decoder.sv */
// ----------------------------------------------------------------------------
// inline_tree_huffman_decoder
// Huffman decoder whose code tree arrives as a preorder header ahead of the
// coded bits; tree and build stack live in RAMs with registered read data.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid_i/s_tready_o  tdata: word[31:0], byte_count[34:32]
//  m_*       out        m_tvalid_o/m_tready_i  tdata: data_byte, tlast: last, tuser: error
//  cfg_*     in         cfg_valid_i/cfg_ready_o index 0 encrypted, 1 output_length
//
//  A word is loaded in ST_WAIT, then each of its 32 bits is handled in turn in
//  ST_BIT, which returns to waiting once the buffer is empty. A header bit is
//  handled in ST_BIT; a finished subtree (leaf or overflow flag) then passes
//  ST_DONE and ST_POP for each stack level it reaches (stack RAM read, then child
//  write). A decode bit passes ST_BIT and ST_DEC (child RAM read, then select).
//  Reset clears control state only; RAMs are not cleared. A full output register
//  stalls the engine only when it has a byte to emit. After the last byte or a
//  root-leaf error, further words are taken and dropped.
`default_nettype none

module inline_tree_huffman_decoder #(
  parameter int unsigned INNER_NODES = ithd_pkg::INNER_NODES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // compressed words
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [39:0] s_tdata_i,   // word[31:0], byte_count[34:32], zero[39:35]
  // decoded bytes
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [7:0]       m_tdata_o,   // data_byte[7:0]
  output logic             m_tlast_o,
  output logic             m_tuser_o,   // error[0]
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);

  import ithd_pkg::*;

  localparam int unsigned AW = (INNER_NODES > 1) ? $clog2(INNER_NODES) : 1;
  localparam int unsigned CW = $clog2(INNER_NODES + 1);
  localparam int unsigned SW = AW + 1;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [31:0]   buf_q, buf_d;
  logic [5:0]    bits_q, bits_d;
  logic [CW-1:0] nodes_q, nodes_d;
  logic [CW-1:0] depth_q, depth_d;
  logic [AW-1:0] walk_q, walk_d;
  logic [3:0]    lcnt_q, lcnt_d;
  logic [7:0]    lacc_q, lacc_d;
  logic [9:0]    val_q, val_d;
  logic          dbit_q, dbit_d;
  logic [23:0]   emitted_q, emitted_d;
  logic          enc_q;
  logic [23:0]   olen_q;

  logic          oval_q, oval_d;
  logic [7:0]    odata_q, odata_d;
  logic          olast_q, olast_d;
  logic          oerr_q, oerr_d;

  // RAM ports
  logic          lc_we, rc_we, ch_re, st_we, st_re;
  logic [AW-1:0] ch_waddr, st_waddr, st_raddr;
  logic [9:0]    ch_wdata, lc_rdata, rc_rdata;
  logic [SW-1:0] st_wdata, st_rdata;

  logic          in_acc, out_free, cur_bit, done_len;
  logic [9:0]    child;
  logic [2:0]    bcnt;
  logic [31:0]   word;
  logic [7:0]    lacc_nx;
  logic [23:0]   emitted_inc;
  logic [AW-1:0] top_node, depth_m1;

  assign s_tready_o  = (state_q == ST_WAIT);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = s_tvalid_i && s_tready_o;
  assign out_free    = !oval_q || m_tready_i;
  assign word        = s_tdata_i[31:0];
  assign bcnt        = s_tdata_i[34:32];
  assign cur_bit     = buf_q[5'(bits_q - 6'd1)];
  assign done_len    = (emitted_q >= olen_q);
  assign child       = dbit_q ? rc_rdata : lc_rdata;
  assign lacc_nx     = {lacc_q[6:0], cur_bit};
  assign emitted_inc = emitted_q + 24'd1;
  assign top_node    = st_rdata[AW-1:0];
  assign depth_m1    = AW'(depth_q - CW'(1));

  assign m_tvalid_o = oval_q;
  assign m_tdata_o  = odata_q;
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = oerr_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WAIT: begin
        if (in_acc && phase_q != PH_IDLE) state_d = ST_BIT;
      end
      ST_BIT: begin
        if (bits_q == 6'd0 || phase_q == PH_IDLE) begin
          state_d = ST_WAIT;
        end else begin
          case (phase_q)
            PH_FLAG: begin
              if (cur_bit && nodes_q >= CW'(INNER_NODES)) state_d = ST_DONE;
            end
            PH_LEAF: begin
              if (lcnt_q == 4'd7) state_d = ST_DONE;
            end
            PH_DECODE: begin
              state_d = done_len ? ST_WAIT : ST_DEC;
            end
            default: state_d = ST_WAIT;
          endcase
        end
      end
      ST_DONE: begin
        if (depth_q != '0) begin
          state_d = ST_POP;
        end else if (val_q[9:8] != 2'b00 || out_free) begin
          state_d = ST_BIT;
        end
      end
      ST_POP: begin
        state_d = st_rdata[AW] ? ST_DONE : ST_BIT;
      end
      ST_DEC: begin
        if (child[9:8] == 2'b01 || out_free) state_d = ST_BIT;
      end
      default: state_d = ST_WAIT;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    phase_d   = phase_q;
    buf_d     = buf_q;
    bits_d    = bits_q;
    nodes_d   = nodes_q;
    depth_d   = depth_q;
    walk_d    = walk_q;
    lcnt_d    = lcnt_q;
    lacc_d    = lacc_q;
    val_d     = val_q;
    dbit_d    = dbit_q;
    emitted_d = emitted_q;
    oval_d    = oval_q && !m_tready_i;
    odata_d   = odata_q;
    olast_d   = olast_q;
    oerr_d    = oerr_q;
    lc_we     = 1'b0;
    rc_we     = 1'b0;
    ch_re     = 1'b0;
    ch_waddr  = top_node;
    ch_wdata  = val_q;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_waddr  = depth_q[AW-1:0];
    st_wdata  = {1'b0, nodes_q[AW-1:0]};
    st_raddr  = depth_m1;

    case (state_q)
      ST_WAIT: begin
        if (in_acc && phase_q != PH_IDLE) begin
          bits_d = 6'd32;
          case (bcnt)
            3'd0: buf_d = buf_q;
            3'd1: buf_d = {buf_q[23:0], word[7:0]};
            3'd2: buf_d = {buf_q[15:0], word[7:0], word[15:8]};
            3'd3: buf_d = {buf_q[7:0], word[7:0], word[15:8], word[23:16]};
            default: buf_d = enc_q ? (word ^ XOR_KEY) : word;
          endcase
        end
      end
      ST_BIT: begin
        if (bits_q != 6'd0 && phase_q != PH_IDLE) begin
          if (phase_q == PH_DECODE && done_len) begin
            phase_d = PH_IDLE;
          end else begin
            bits_d = bits_q - 6'd1;
            case (phase_q)
              PH_FLAG: begin
                if (!cur_bit) begin
                  phase_d = PH_LEAF;
                  lcnt_d  = 4'd0;
                  lacc_d  = 8'd0;
                end else if (nodes_q >= CW'(INNER_NODES)) begin
                  val_d = SENTINEL;
                end else begin
                  // push the new inner node, left side pending
                  st_we   = 1'b1;
                  depth_d = depth_q + CW'(1);
                  nodes_d = nodes_q + CW'(1);
                end
              end
              PH_LEAF: begin
                lacc_d = lacc_nx;
                lcnt_d = lcnt_q + 4'd1;
                val_d  = {2'b00, lacc_nx};
              end
              default: begin
                ch_re  = 1'b1;
                dbit_d = cur_bit;
              end
            endcase
          end
        end
      end
      ST_DONE: begin
        if (depth_q != '0) begin
          st_re = 1'b1;
        end else if (val_q[9:8] == 2'b00) begin
          // root is a leaf: report it once, then go idle
          if (out_free) begin
            oval_d  = 1'b1;
            odata_d = val_q[7:0];
            olast_d = 1'b1;
            oerr_d  = 1'b1;
            phase_d = PH_IDLE;
          end
        end else begin
          walk_d  = '0;
          phase_d = done_len ? PH_IDLE : PH_DECODE;
        end
      end
      ST_POP: begin
        if (!st_rdata[AW]) begin
          lc_we    = 1'b1;
          st_we    = 1'b1;
          st_waddr = depth_m1;
          st_wdata = {1'b1, top_node};
          phase_d  = PH_FLAG;
        end else begin
          rc_we   = 1'b1;
          depth_d = depth_q - CW'(1);
          val_d   = NODE_BASE + 10'(top_node);
        end
      end
      ST_DEC: begin
        if (child[9:8] == 2'b01) begin
          walk_d = AW'(child[7:0]);
        end else if (out_free) begin
          // leaf or sentinel: emit and restart at the root
          oval_d    = 1'b1;
          odata_d   = child[7:0];
          olast_d   = (emitted_inc >= olen_q);
          oerr_d    = 1'b0;
          emitted_d = emitted_inc;
          walk_d    = '0;
          if (emitted_inc >= olen_q) phase_d = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_WAIT;
      phase_q   <= PH_FLAG;
      buf_q     <= '0;
      bits_q    <= '0;
      nodes_q   <= '0;
      depth_q   <= '0;
      walk_q    <= '0;
      lcnt_q    <= '0;
      lacc_q    <= '0;
      emitted_q <= '0;
      oval_q    <= 1'b0;
      enc_q     <= 1'b0;
      olen_q    <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      buf_q     <= buf_d;
      bits_q    <= bits_d;
      nodes_q   <= nodes_d;
      depth_q   <= depth_d;
      walk_q    <= walk_d;
      lcnt_q    <= lcnt_d;
      lacc_q    <= lacc_d;
      emitted_q <= emitted_d;
      oval_q    <= oval_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ENCRYPTED:  enc_q  <= cfg_data_i[0];
          CFG_OUT_LENGTH: olen_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    dbit_q  <= dbit_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  ithd_ram #(.WIDTH(10), .DEPTH(INNER_NODES)) u_left (
    .clk_i   (clk_i),
    .we_i    (lc_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .re_i    (ch_re),
    .raddr_i (walk_q),
    .rdata_o (lc_rdata)
  );

  ithd_ram #(.WIDTH(10), .DEPTH(INNER_NODES)) u_right (
    .clk_i   (clk_i),
    .we_i    (rc_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .re_i    (ch_re),
    .raddr_i (walk_q),
    .rdata_o (rc_rdata)
  );

  ithd_ram #(.WIDTH(SW), .DEPTH(INNER_NODES)) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

endmodule

`default_nettype wire

/* rtl/ithd_checker.sv */
// ----------------------------------------------------------------------------
// ithd_props
// Port-level checks of the Huffman decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ithd_props (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_tvalid_o,
  input wire logic       m_tready_i,
  input wire logic [7:0] m_tdata_o,
  input wire logic       m_tlast_o,
  input wire logic       m_tuser_o,
  input wire logic       cfg_ready_o
);

  // an error item always closes the stream
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tlast_o)
    else $error("error item without last");

  // nothing follows the final item
  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && m_tlast_o |=> !m_tvalid_o)
    else $error("item after last");

  // a stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tlast_o))
    else $error("stalled item changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port stalled");

endmodule

bind inline_tree_huffman_decoder ithd_props u_ithd_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .m_tvalid_o  (m_tvalid_o),
  .m_tready_i  (m_tready_i),
  .m_tdata_o   (m_tdata_o),
  .m_tlast_o   (m_tlast_o),
  .m_tuser_o   (m_tuser_o),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire
